// ===== src/spwc_pkg.sv =====
// Shared types and constants for the shadow page write coalescer.
// Holds the request and result item layouts and the result kind codes.
// No dependencies; every other file imports this package.
package spwc_pkg;

  localparam int ADDR_W  = 16;
  localparam int LEN_W   = 17;
  localparam int SIZE_W  = 17;
  localparam int DATA_W  = 8;
  localparam int FIRST_W = 11;
  localparam int COUNT_W = 12;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(65536);
  localparam int                SIZE_MAX   = (2 ** SIZE_W) - 1;
  localparam logic [DATA_W-1:0] ERASED     = 8'hFF;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_WRITEBACK = 2'd0,
    KIND_DONE      = 2'd1,
    KIND_REJECT    = 2'd2
  } kind_t;

  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  length;
    logic [DATA_W-1:0] data;
    logic              dummy;
    logic              last;
  } in_item_t;

  typedef struct packed {
    kind_t              kind;
    logic [FIRST_W-1:0] first_page;
    logic [COUNT_W-1:0] page_count;
    logic               last_result;
  } result_t;

  // Results produced by one request byte, zero to two of them.
  typedef struct packed {
    logic [1:0] count;
    result_t    slot0;
    result_t    slot1;
  } result_push_t;

endpackage

// ===== src/spwc_if.sv =====
// Valid/ready channel interfaces for request bytes and result items.
// Depends on spwc_pkg for the field widths.
interface spwc_in_if import spwc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [ADDR_W-1:0] address;
  logic [LEN_W-1:0]  length;
  logic [DATA_W-1:0] data;
  logic              dummy;
  logic              last;

  modport source (output valid, mode, address, length, data, dummy, last, input ready);
  modport sink   (input valid, mode, address, length, data, dummy, last, output ready);
endinterface

interface spwc_out_if import spwc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [FIRST_W-1:0] first_page;
  logic [COUNT_W-1:0] page_count;
  logic               last_result;

  modport source (output valid, kind, first_page, page_count, last_result, input ready);
  modport sink   (input valid, kind, first_page, page_count, last_result, output ready);
endinterface

// ===== src/spwc_shadow_ram.sv =====
// Byte shadow memory: one read port with registered data, one write port.
// After reset a sweep writes the erased value into every entry.
// Depends on spwc_pkg.
module spwc_shadow_ram import spwc_pkg::*; #(
  parameter int MEM_BYTES = 65536,
  parameter int IDX_W     = $clog2(MEM_BYTES)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_idx,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_idx,
  input  logic [DATA_W-1:0] wr_data,
  output logic              clearing
);

  logic [DATA_W-1:0] mem [MEM_BYTES];
  logic [IDX_W-1:0]  clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == IDX_W'(MEM_BYTES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= ERASED;
    end else if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule

// ===== src/spwc_page_tracker.sv =====
// Two-stage request pipeline: page number and bounds check, then the
// shadow compare/update with write forwarding and the dirty-run tracking.
// Depends on spwc_pkg; drives the write port of spwc_shadow_ram.
module spwc_page_tracker import spwc_pkg::*; #(
  parameter int PAGE_BYTES = 32,
  parameter int IDX_W      = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  in_item_t          item,
  input  logic [IDX_W-1:0]  item_idx,
  input  logic [SIZE_W-1:0] limit,
  input  logic [DATA_W-1:0] rd_data,
  output logic              wr_en,
  output logic [IDX_W-1:0]  wr_idx,
  output logic [DATA_W-1:0] wr_data,
  output result_push_t      push,
  output logic [1:0]        inflight
);

  localparam int PB_L   = $clog2(PAGE_BYTES);
  localparam int PROD_W = 2 * ADDR_W + 1;
  // Reciprocal that gives an exact quotient for every 16-bit address.
  localparam longint RECIP = (longint'(2) ** (ADDR_W + PB_L)) / PAGE_BYTES + 1;
  localparam int RUN_W  = $clog2(((2 ** ADDR_W) - 1) / PAGE_BYTES + 2);

  // First stage.
  logic              s1_valid;
  in_item_t          s1_item;
  logic [IDX_W-1:0]  s1_idx;
  logic [PROD_W-1:0] s1_prod;
  logic [RUN_W-1:0]  s1_page;
  logic              s1_over;

  // Second stage.
  logic              s2_valid;
  in_item_t          s2_item;
  logic [IDX_W-1:0]  s2_idx;
  logic [RUN_W-1:0]  s2_page;
  logic              s2_over;
  logic [DATA_W-1:0] s2_rdata;

  // Recent writes that the stage-two read data can miss, kept in two forwarding registers.
  logic              fw1_en, fw2_en;
  logic [IDX_W-1:0]  fw1_idx, fw2_idx;
  logic [DATA_W-1:0] fw1_data, fw2_data;

  // Request state.
  logic              active;
  logic              rejected;
  logic              pd;
  logic [RUN_W-1:0]  run_b;
  logic [RUN_W-1:0]  run_e;

  logic [DATA_W-1:0] cur;
  logic [ADDR_W:0]   page_last_addr;
  logic              closing;
  logic [RUN_W-1:0]  page_inc;
  logic              rej_c;
  logic              pd_c;
  logic [RUN_W-1:0]  rb_c;
  logic [RUN_W-1:0]  re_c;
  logic [1:0]        n_c;
  logic              wr_c;
  result_t           slot0;
  result_t           slot1;

  function automatic result_t make_wb(input logic [RUN_W-1:0] b, input logic [RUN_W-1:0] e);
    result_t r;
    r             = '0;
    r.kind        = KIND_WRITEBACK;
    r.first_page  = FIRST_W'(b);
    r.page_count  = COUNT_W'(e - b);
    r.last_result = 1'b0;
    return r;
  endfunction

  function automatic result_t make_end(input logic rej);
    result_t r;
    r             = '0;
    r.kind        = rej ? KIND_REJECT : KIND_DONE;
    r.last_result = 1'b0;
    return r;
  endfunction

  assign s1_prod = PROD_W'(s1_item.address) * PROD_W'(RECIP);
  assign s1_page = RUN_W'(s1_prod >> (ADDR_W + PB_L));
  assign s1_over = ({1'b0, s1_item.address} >= limit) ||
                   ((ADDR_W + 2)'(s1_item.address) + (ADDR_W + 2)'(s1_item.length) >
                    (ADDR_W + 2)'(limit));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      fw1_en   <= 1'b0;
      fw2_en   <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      fw1_en   <= wr_en;
      fw2_en   <= fw1_en;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item;
      s1_idx  <= item_idx;
    end
    s2_item  <= s1_item;
    s2_idx   <= s1_idx;
    s2_page  <= s1_page;
    s2_over  <= s1_over;
    s2_rdata <= rd_data;
    fw1_idx  <= wr_idx;
    fw1_data <= wr_data;
    fw2_idx  <= fw1_idx;
    fw2_data <= fw1_data;
  end

  assign page_last_addr = (ADDR_W + 1)'(s2_page) * (ADDR_W + 1)'(PAGE_BYTES) +
                          (ADDR_W + 1)'(PAGE_BYTES - 1);
  assign closing  = s2_item.last || ({1'b0, s2_item.address} == page_last_addr);
  assign page_inc = s2_page + 1'b1;

  always_comb begin
    if (fw1_en && fw1_idx == s2_idx) begin
      cur = fw1_data;
    end else if (fw2_en && fw2_idx == s2_idx) begin
      cur = fw2_data;
    end else begin
      cur = s2_rdata;
    end
  end

  always_comb begin
    rej_c = active ? rejected : s2_over;
    pd_c  = active ? pd : 1'b0;
    rb_c  = active ? run_b : '0;
    re_c  = active ? run_e : '0;
    n_c   = 2'd0;
    wr_c  = 1'b0;
    slot0 = '0;
    slot1 = '0;

    if (!rej_c) begin
      wr_c = s2_item.mode || !s2_item.dummy;
      pd_c = pd_c | (s2_item.mode && (cur != s2_item.data));
      if (closing) begin
        if (pd_c) begin
          if (rb_c == re_c) begin
            rb_c = s2_page;
            re_c = page_inc;
          end else begin
            if (s2_page < rb_c) begin
              rb_c = s2_page;
            end
            if (page_inc > re_c) begin
              re_c = page_inc;
            end
          end
        end else if (rb_c != re_c) begin
          // A clean page ends the run.
          slot0 = make_wb(rb_c, re_c);
          n_c   = 2'd1;
          rb_c  = '0;
          re_c  = '0;
        end
        pd_c = 1'b0;
      end
      if (s2_item.last && rb_c != re_c) begin
        if (n_c == 2'd0) begin
          slot0 = make_wb(rb_c, re_c);
        end else begin
          slot1 = make_wb(rb_c, re_c);
        end
        n_c  = n_c + 2'd1;
        rb_c = '0;
        re_c = '0;
      end
    end

    if (s2_item.last) begin
      if (n_c == 2'd0) begin
        slot0 = make_end(rej_c);
      end else begin
        slot1 = make_end(rej_c);
      end
      n_c = n_c + 2'd1;
    end

    if (n_c == 2'd1) begin
      slot0.last_result = 1'b1;
    end else if (n_c == 2'd2) begin
      slot1.last_result = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      rejected <= 1'b0;
      pd       <= 1'b0;
      run_b    <= '0;
      run_e    <= '0;
    end else if (s2_valid) begin
      if (s2_item.last) begin
        active   <= 1'b0;
        rejected <= 1'b0;
        pd       <= 1'b0;
        run_b    <= '0;
        run_e    <= '0;
      end else begin
        active   <= 1'b1;
        rejected <= rej_c;
        pd       <= pd_c;
        run_b    <= rb_c;
        run_e    <= re_c;
      end
    end
  end

  assign wr_en      = s2_valid && wr_c;
  assign wr_idx     = s2_idx;
  assign wr_data    = s2_item.data;
  assign push.count = s2_valid ? n_c : 2'd0;
  assign push.slot0 = slot0;
  assign push.slot1 = slot1;
  assign inflight   = {1'b0, s1_valid} + {1'b0, s2_valid};

endmodule

// ===== src/spwc_result_fifo.sv =====
// Small result queue that takes up to two results a cycle and hands out one whenever the output is ready.
// Depends on spwc_pkg and spwc_out_if.
module spwc_result_fifo import spwc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  result_push_t          push,
  output logic [FIFO_CNT_W-1:0] level,
  spwc_out_if.source            out_res
);

  result_t                 entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr;
  logic [FIFO_PTR_W-1:0]   rd_ptr;
  logic                    pop;
  result_t                 head;

  assign pop  = out_res.valid && out_res.ready;
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(push.count);
      rd_ptr <= rd_ptr + FIFO_PTR_W'(pop);
      level  <= level + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.slot0;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + 1'b1] <= push.slot1;
    end
  end

  assign out_res.valid       = (level != '0);
  assign out_res.kind        = head.kind;
  assign out_res.first_page  = head.first_page;
  assign out_res.page_count  = head.page_count;
  assign out_res.last_result = head.last_result;

endmodule

// ===== src/shadow_page_write_coalescer.sv =====
// Shadow page write coalescer. Takes one request byte per clock and returns
// write-back page ranges plus a done or rejected result for each request.
// After reset the shadow memory is swept to 0xFF, one byte a cycle, so no
// request is accepted until the sweep has finished. Each byte then passes
// a two-stage pipeline: the page and bounds stage runs while the shadow read
// completes, then the compare and write-back stage pushes the byte's results
// into the result queue, from which the output hands them out. A new byte is
// taken every cycle while input ready is high; the shadow memory's single read
// and write port sets that rate. Input ready drops during the sweep and when
// the eight-entry result queue could overflow, that is when the consumer
// takes results more slowly than they are produced.
// Depends on spwc_pkg, spwc_if, spwc_shadow_ram, spwc_page_tracker and
// spwc_result_fifo.
module shadow_page_write_coalescer import spwc_pkg::*; #(
  parameter int MEM_BYTES  = 65536,
  parameter int PAGE_BYTES = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_en,
  input  logic [SIZE_W-1:0] cfg_write_data,
  spwc_in_if.sink           in_req,
  spwc_out_if.source        out_res
);

  localparam int IDX_W     = $clog2(MEM_BYTES);
  localparam int LIM_CAP   = (MEM_BYTES > SIZE_MAX) ? SIZE_MAX : MEM_BYTES;
  localparam int RED_STEPS = (MEM_BYTES >= (2 ** ADDR_W)) ? 0 :
                             $clog2(((2 ** ADDR_W) + MEM_BYTES - 1) / MEM_BYTES);

  logic [SIZE_W-1:0]     size_bytes;
  logic [SIZE_W-1:0]     limit;
  logic                  accept;
  logic                  clearing;
  in_item_t              item;
  logic [ADDR_W:0]       red;
  logic [IDX_W-1:0]      item_idx;
  logic [DATA_W-1:0]     rd_data;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_idx;
  logic [DATA_W-1:0]     wr_data;
  result_push_t          push;
  logic [1:0]            inflight;
  logic [FIFO_CNT_W-1:0] level;
  logic [FIFO_CNT_W+1:0] committed;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_bytes <= SIZE_RESET;
    end else if (cfg_write_en) begin
      size_bytes <= cfg_write_data;
    end
  end

  assign limit = (size_bytes > SIZE_W'(LIM_CAP)) ? SIZE_W'(LIM_CAP) : size_bytes;

  assign item.mode    = in_req.mode;
  assign item.address = in_req.address;
  assign item.length  = in_req.length;
  assign item.data    = in_req.data;
  assign item.dummy   = in_req.dummy;
  assign item.last    = in_req.last;

  // Address modulo the memory size by compare and subtract of shifted sizes.
  always_comb begin
    red = {1'b0, in_req.address};
    for (int k = RED_STEPS - 1; k >= 0; k--) begin
      if (red >= ((ADDR_W + 1)'(MEM_BYTES) << k)) begin
        red = red - ((ADDR_W + 1)'(MEM_BYTES) << k);
      end
    end
  end

  assign item_idx = IDX_W'(red);

  // Every byte in flight, and the new one, may add two results.
  assign committed = (FIFO_CNT_W + 2)'(level) + (FIFO_CNT_W + 2)'({inflight, 1'b0}) +
                     (FIFO_CNT_W + 2)'(2);
  assign in_req.ready = !clearing && (committed <= (FIFO_CNT_W + 2)'(FIFO_DEPTH));
  assign accept       = in_req.valid && in_req.ready;

  spwc_shadow_ram #(
    .MEM_BYTES (MEM_BYTES),
    .IDX_W     (IDX_W)
  ) u_ram (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_idx   (item_idx),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_idx   (wr_idx),
    .wr_data  (wr_data),
    .clearing (clearing)
  );

  spwc_page_tracker #(
    .PAGE_BYTES (PAGE_BYTES),
    .IDX_W      (IDX_W)
  ) u_tracker (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .item_idx (item_idx),
    .limit    (limit),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_idx   (wr_idx),
    .wr_data  (wr_data),
    .push     (push),
    .inflight (inflight)
  );

  spwc_result_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .level   (level),
    .out_res (out_res)
  );

endmodule

// ===== tb/shadow_page_write_coalescer_test.sv =====
// Self-checking testbench for the shadow page write coalescer: streams request
// bytes, predicts write-back ranges and request status, and checks each result.
// Depends on spwc_pkg, spwc_if and the shadow_page_write_coalescer RTL.
`timescale 1ns / 1ps

module shadow_page_write_coalescer_test;
  import spwc_pkg::*;

  localparam int MEM_SPAN  = 65536;
  localparam int PAGE_SPAN = 32;
  localparam bit MODE_FILL = 1'b0;
  localparam bit MODE_HOST = 1'b1;

  typedef enum {FILL_RUN, HOST_RUN, MIXED_RUN, SCATTER_RUN} burst_style_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write_en;
  logic [SIZE_W-1:0] cfg_write_data;

  spwc_in_if  req_ch ();
  spwc_out_if res_ch ();

  shadow_page_write_coalescer #(
    .MEM_BYTES (MEM_SPAN),
    .PAGE_BYTES(PAGE_SPAN)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_req        (req_ch),
    .out_res       (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted block state.
  logic [7:0]  shadow_copy [MEM_SPAN];
  int unsigned cur_size;
  int unsigned run_lo, run_hi;
  bit          pg_dirty, in_request, in_reject;

  // Generator-side view of memory, used only to shape write data.
  logic [7:0]  gen_mem [MEM_SPAN];
  int unsigned gen_size;

  in_item_t byte_queue [$];
  result_t  owed_results [$];
  in_item_t on_wire;

  int bytes_made = 0;
  int bytes_taken = 0;
  int results_due = 0;
  int results_seen = 0;
  int mismatches = 0;
  int wb_seen = 0;
  int reject_seen = 0;
  int size_settings = 0;

  int stall_left = 0;
  bit stall_done = 1'b0;

  function automatic result_t make_result(kind_t k, int unsigned first, int unsigned count);
    result_t r;
    r.kind        = k;
    r.first_page  = FIRST_W'(first);
    r.page_count  = COUNT_W'(count);
    r.last_result = 1'b0;
    return r;
  endfunction

  // Applies one accepted request byte and queues the results it causes.
  function automatic int shadow_apply_byte(in_item_t b);
    result_t           made [$];
    int unsigned       lim, pg, addr, len;
    logic [ADDR_W-1:0] idx;
    addr = 32'(b.address);
    len  = 32'(b.length);
    idx  = b.address;
    if (!in_request) begin
      lim        = (cur_size > MEM_SPAN) ? MEM_SPAN : cur_size;
      in_request = 1'b1;
      in_reject  = (addr >= lim) || (addr + len > lim);
      run_lo     = 0;
      run_hi     = 0;
      pg_dirty   = 1'b0;
    end
    if (!in_reject) begin
      if (b.mode == MODE_HOST) begin
        if (shadow_copy[idx] != b.data) begin
          pg_dirty         = 1'b1;
          shadow_copy[idx] = b.data;
        end
      end else if (!b.dummy) begin
        shadow_copy[idx] = b.data;
      end
      if (b.last || (addr + 1) % PAGE_SPAN == 0) begin
        pg = addr / PAGE_SPAN;
        if (pg_dirty) begin
          if (run_lo == run_hi) begin
            run_lo = pg;
            run_hi = pg + 1;
          end else begin
            if (pg < run_lo) run_lo = pg;
            if (pg + 1 > run_hi) run_hi = pg + 1;
          end
        end else if (run_lo != run_hi) begin
          // A clean page breaks the run.
          made.push_back(make_result(KIND_WRITEBACK, run_lo, run_hi - run_lo));
          run_lo = 0;
          run_hi = 0;
        end
        pg_dirty = 1'b0;
      end
      if (b.last && run_lo != run_hi) begin
        made.push_back(make_result(KIND_WRITEBACK, run_lo, run_hi - run_lo));
      end
    end
    if (b.last) begin
      made.push_back(make_result(in_reject ? KIND_REJECT : KIND_DONE, 0, 0));
      in_request = 1'b0;
      in_reject  = 1'b0;
      run_lo     = 0;
      run_hi     = 0;
      pg_dirty   = 1'b0;
    end
    if (made.size() > 0) made[made.size() - 1].last_result = 1'b1;
    foreach (made[i]) owed_results.push_back(made[i]);
    return made.size();
  endfunction

  function automatic bit quiet_stretch();
    return bytes_taken >= 700 && bytes_taken < 1000;
  endfunction

  // Request driver.
  always @(posedge clk) begin
    int n;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        n = shadow_apply_byte(on_wire);
        results_due <= results_due + n;
        bytes_taken <= bytes_taken + 1;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (byte_queue.size() > 0 && (quiet_stretch() || $urandom_range(0, 99) >= 24)) begin
          on_wire        = byte_queue.pop_front();
          req_ch.valid   <= 1'b1;
          req_ch.mode    <= on_wire.mode;
          req_ch.address <= on_wire.address;
          req_ch.length  <= on_wire.length;
          req_ch.data    <= on_wire.data;
          req_ch.dummy   <= on_wire.dummy;
          req_ch.last    <= on_wire.last;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result consumer; one long hold-off lets the result queue back up into the input.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      res_ch.ready <= 1'b0;
    end else if (!stall_done && bytes_taken >= 400) begin
      stall_left   <= 300;
      stall_done   <= 1'b1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= quiet_stretch() || $urandom_range(0, 99) >= 24;
    end
  end

  // Result monitor. Sampling at the falling edge sees the values that the next
  // rising edge will take, after all updates of the previous rising edge.
  always @(negedge clk) begin
    result_t want;
    int      bad;
    if (!rst && res_ch.valid && res_ch.ready) begin
      bad = 0;
      if (owed_results.size() == 0) begin
        $error("unexpected result: kind %0d first_page %0d page_count %0d",
               res_ch.kind, res_ch.first_page, res_ch.page_count);
        bad = 1;
      end else begin
        want = owed_results.pop_front();
        if (res_ch.kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, res_ch.kind);
          bad++;
        end
        if (res_ch.first_page !== want.first_page) begin
          $error("first_page: expected %0d, actual %0d", want.first_page, res_ch.first_page);
          bad++;
        end
        if (res_ch.page_count !== want.page_count) begin
          $error("page_count: expected %0d, actual %0d", want.page_count, res_ch.page_count);
          bad++;
        end
        if (res_ch.last_result !== want.last_result) begin
          $error("last_result: expected %0d, actual %0d", want.last_result,
                 res_ch.last_result);
          bad++;
        end
      end
      if (res_ch.kind == KIND_WRITEBACK) wb_seen++;
      if (res_ch.kind == KIND_REJECT) reject_seen++;
      results_seen <= results_seen + 1;
      if (bad != 0) mismatches <= mismatches + bad;
    end
  end

  function automatic void push_byte(bit md, int unsigned addr, int unsigned len,
                                    logic [7:0] d, bit dmy, bit lst, bit keep);
    in_item_t b;
    b.mode    = md;
    b.address = ADDR_W'(addr);
    b.length  = LEN_W'(len);
    b.data    = d;
    b.dummy   = dmy;
    b.last    = lst;
    byte_queue.push_back(b);
    if (keep && (md == MODE_HOST || !dmy)) gen_mem[ADDR_W'(addr % MEM_SPAN)] = d;
    bytes_made++;
  endfunction

  // Queues one request. Host-mode bytes mostly repeat what the memory already holds,
  // so that clean pages fall between dirty ones.
  task automatic add_request(burst_style_t style, int unsigned start, int unsigned len,
                             int unsigned nbytes);
    int unsigned lim, a;
    bit          keep, md, dirty_pg;
    logic [7:0]  d;
    lim      = (gen_size > MEM_SPAN) ? MEM_SPAN : gen_size;
    keep     = !(start >= lim || start + len > lim);
    dirty_pg = 1'b0;
    for (int i = 0; i < nbytes; i++) begin
      if (style == SCATTER_RUN) begin
        a = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MEM_SPAN - 1)
                                         : (start + $urandom_range(0, 255)) % MEM_SPAN;
      end else begin
        a = (start + i) % MEM_SPAN;
      end
      case (style)
        FILL_RUN: md = MODE_FILL;
        HOST_RUN: md = MODE_HOST;
        default:  md = 1'($urandom_range(0, 1));
      endcase
      if (i == 0 || a % PAGE_SPAN == 0) dirty_pg = 1'($urandom_range(0, 1));
      if (md == MODE_FILL) d = 8'($urandom_range(0, 255));
      else if (dirty_pg && $urandom_range(0, 2) == 0)
        d = gen_mem[ADDR_W'(a)] ^ 8'($urandom_range(1, 255));
      else d = gen_mem[ADDR_W'(a)];
      push_byte(md, a, len, d, $urandom_range(0, 3) == 0, i == nbytes - 1, keep);
    end
  endtask

  task automatic set_size(int unsigned size);
    @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= SIZE_W'(size);
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    cur_size = size;
    gen_size = size;
    size_settings++;
  endtask

  // Waits until every queued byte is taken and every result has arrived, then
  // gives the pipeline time to finish bytes that cause no result.
  task automatic drain();
    do @(negedge clk);
    while (byte_queue.size() != 0 || req_ch.valid || results_seen < results_due);
    repeat (12) @(negedge clk);
  endtask

  task automatic random_phase(int unsigned size, int target);
    int unsigned lim, len, start, hi, pick, style_pick;
    int          goal;
    set_size(size);
    lim  = (size > MEM_SPAN) ? MEM_SPAN : size;
    goal = bytes_made + target;
    while (bytes_made < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(81, 300) : $urandom_range(1, 80);
        if (len > lim) len = lim;
        hi = lim - len;
        // Half the time stay in the low pages so data gets rewritten.
        if ($urandom_range(0, 1) && hi > 2048) hi = 2048;
        start = $urandom_range(0, hi);
        if ($urandom_range(0, 2) == 0) start = start - start % PAGE_SPAN;
        style_pick = $urandom_range(0, 99);
        add_request(style_pick < 40 ? HOST_RUN : style_pick < 80 ? FILL_RUN : MIXED_RUN,
                    start, len, len);
      end else if (pick < 80) begin
        len   = $urandom_range(1, lim < 64 ? lim : 64);
        start = $urandom_range(0, lim - len);
        add_request(SCATTER_RUN, start, len, $urandom_range(1, 8));
      end else if (pick < 92) begin
        if (lim < MEM_SPAN && $urandom_range(0, 1)) begin
          start = $urandom_range(lim, MEM_SPAN - 1);
          len   = $urandom_range(1, 64);
        end else begin
          start = $urandom_range(0, lim - 1);
          len   = lim - start + $urandom_range(1, 64);
        end
        add_request(MIXED_RUN, start, len, $urandom_range(1, len < 6 ? len : 6));
      end else begin
        add_request(MIXED_RUN, $urandom_range(0, MEM_SPAN - 1), $urandom_range(0, 131071),
                    $urandom_range(1, 4));
      end
    end
    drain();
  endtask

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    cfg_write_en   = 1'b0;
    cfg_write_data = '0;
    req_ch.valid   = 1'b0;
    req_ch.mode    = 1'b0;
    req_ch.address = '0;
    req_ch.length  = '0;
    req_ch.data    = '0;
    req_ch.dummy   = 1'b0;
    req_ch.last    = 1'b0;
    res_ch.ready   = 1'b0;
    foreach (shadow_copy[i]) shadow_copy[i] = ERASED;
    foreach (gen_mem[i]) gen_mem[i] = ERASED;
    cur_size   = 32'(SIZE_RESET);
    gen_size   = 32'(SIZE_RESET);
    run_lo     = 0;
    run_hi     = 0;
    pg_dirty   = 1'b0;
    in_request = 1'b0;
    in_reject  = 1'b0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    set_size(65536);
    // Fill with one dummy byte, then write the same values back: only the
    // skipped byte still differs.
    push_byte(MODE_FILL, 0, 3, 8'h00, 1'b0, 1'b0, 1'b1);
    push_byte(MODE_FILL, 1, 3, 8'hA5, 1'b1, 1'b0, 1'b1);
    push_byte(MODE_FILL, 2, 3, 8'h5A, 1'b0, 1'b1, 1'b1);
    push_byte(MODE_HOST, 0, 3, 8'h00, 1'b0, 1'b0, 1'b1);
    push_byte(MODE_HOST, 1, 3, 8'hA5, 1'b1, 1'b0, 1'b1);
    push_byte(MODE_HOST, 2, 3, 8'h5A, 1'b0, 1'b1, 1'b1);
    // Two dirty pages across a page boundary merge into one range.
    push_byte(MODE_HOST, 30, 4, 8'h11, 1'b0, 1'b0, 1'b1);
    push_byte(MODE_HOST, 31, 4, 8'h22, 1'b0, 1'b0, 1'b1);
    push_byte(MODE_HOST, 32, 4, 8'h33, 1'b0, 1'b0, 1'b1);
    push_byte(MODE_HOST, 33, 4, 8'h44, 1'b1, 1'b1, 1'b1);
    // First and last page of memory in one run: the widest range.
    push_byte(MODE_HOST, 31, 1, 8'h00, 1'b0, 1'b0, 1'b1);
    push_byte(MODE_HOST, 65535, 1, 8'h00, 1'b0, 1'b1, 1'b1);
    // A clean page in the middle flushes the run early.
    push_byte(MODE_HOST, 95, 1, 8'h12, 1'b0, 1'b0, 1'b1);
    push_byte(MODE_HOST, 127, 1, 8'hFF, 1'b0, 1'b0, 1'b1);
    push_byte(MODE_HOST, 159, 1, 8'h34, 1'b0, 1'b1, 1'b1);
    // A clean page that closes on the last byte gives a range and the status.
    push_byte(MODE_HOST, 191, 1, 8'h56, 1'b0, 1'b0, 1'b1);
    push_byte(MODE_HOST, 223, 1, 8'hFF, 1'b0, 1'b1, 1'b1);
    // A dirty page below the run widens it downward.
    push_byte(MODE_HOST, 351, 1, 8'h9C, 1'b0, 1'b0, 1'b1);
    push_byte(MODE_HOST, 287, 1, 8'h9C, 1'b0, 1'b1, 1'b1);
    // Zero length, full length, and full length one byte too far.
    push_byte(MODE_HOST, 500, 0, 8'h00, 1'b0, 1'b1, 1'b1);
    push_byte(MODE_FILL, 0, 65536, 8'hC3, 1'b0, 1'b1, 1'b1);
    push_byte(MODE_HOST, 1, 65536, 8'h3C, 1'b0, 1'b1, 1'b0);
    drain();

    // Smallest memory: only a one-byte request at address zero fits.
    set_size(1);
    push_byte(MODE_HOST, 0, 1, 8'h77, 1'b0, 1'b1, 1'b1);
    push_byte(MODE_HOST, 0, 2, 8'h78, 1'b0, 1'b1, 1'b0);
    push_byte(MODE_FILL, 1, 1, 8'h79, 1'b0, 1'b0, 1'b0);
    push_byte(MODE_HOST, 2, 1, 8'h7A, 1'b0, 1'b1, 1'b0);
    drain();

    random_phase(65536, 400);
    random_phase($urandom_range(2048, 65535), 400);
    random_phase($urandom_range(64, 1023), 400);
    random_phase(65536, 400);

    @(posedge clk);
    $display("tb: sent %0d request bytes under %0d memory size settings",
             bytes_taken, size_settings);
    $display("tb: checked %0d results, %0d write-back ranges and %0d rejections",
             results_seen, wb_seen, reject_seen);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
